FILE: design/hvd_pkg.sv
// ----------------------------------------------------------------------------
// hvd_pkg
// Shared constants, widths and tables for the haversine distance pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package hvd_pkg;

	localparam int ANGLE_FRAC_BITS = 22;
	localparam int DIST_FRAC_BITS  = 4;
	localparam int CORDIC_STAGES   = 24;

	localparam int ANGLE_W  = 31;
	localparam int RADIUS_W = 26;
	localparam int DIST_W   = 32;

	// degrees to binary angle: |d| << BAM_SHIFT, then divide by 360 or 720
	localparam int BAM_SHIFT = 32 - ANGLE_FRAC_BITS;
	localparam int MAG_W     = 32 + BAM_SHIFT;
	localparam int DIV_LO_W  = 20;
	localparam logic [26:0] RECIP45 = 27'd95443717;   // floor(2^32 / 45)

	localparam int CORDIC_W = 34;
	localparam logic signed [CORDIC_W-1:0] CORDIC_K = CORDIC_W'(652032874);
	localparam logic signed [CORDIC_W-1:0] QUARTER_TURN = CORDIC_W'(64'd1 << 30);
	localparam logic signed [CORDIC_W-1:0] HALF_TURN = CORDIC_W'(64'd1 << 31);

	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	localparam logic [30:0] PI_Q29  = 31'd1686629713;
	localparam int THETA_SHIFT = 27;
	localparam int DIST_SHIFT  = 32 - DIST_FRAC_BITS;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(20908120);

	// register indexes
	localparam logic [1:0] REG_HOME_LAT = 2'd0;
	localparam logic [1:0] REG_HOME_LON = 2'd1;
	localparam logic [1:0] REG_RADIUS   = 2'd2;

	// pipeline depths
	localparam int BAM_LAT  = 3;
	localparam int SC_LAT   = CORDIC_STAGES + 2;
	localparam int PROD_LAT = 3;
	localparam int ISQ_ITER = 32;
	localparam int ISQ_LAT  = ISQ_ITER + 1;
	localparam int AT_LAT   = CORDIC_STAGES + 2;
	localparam int FIN_LAT  = 4;
	localparam int TOTAL_LAT = BAM_LAT + SC_LAT + PROD_LAT + ISQ_LAT + AT_LAT + FIN_LAT;

	// atan(2^-i) in binary-angle units (2^32 per turn)
	function automatic logic signed [CORDIC_W-1:0] atan_angle(input int i);
		logic [31:0] v;
		case (i)
			0: v = 32'h20000000;
			1: v = 32'h12E4051E;
			2: v = 32'h09FB385B;
			3: v = 32'h051111D4;
			4: v = 32'h028B0D43;
			5: v = 32'h0145D7E1;
			6: v = 32'h00A2F61E;
			7: v = 32'h00517C55;
			8: v = 32'h0028BE53;
			9: v = 32'h00145F2F;
			10: v = 32'h000A2F98;
			11: v = 32'h000517CC;
			12: v = 32'h00028BE6;
			13: v = 32'h000145F3;
			14: v = 32'h0000A2FA;
			15: v = 32'h0000517D;
			16: v = 32'h000028BE;
			17: v = 32'h0000145F;
			18: v = 32'h00000A30;
			19: v = 32'h00000518;
			20: v = 32'h0000028C;
			21: v = 32'h00000146;
			22: v = 32'h000000A3;
			23: v = 32'h00000051;
			24: v = 32'h00000029;
			25: v = 32'h00000014;
			26: v = 32'h0000000A;
			27: v = 32'h00000005;
			28: v = 32'h00000003;
			29: v = 32'h00000001;
			30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return CORDIC_W'(v);
	endfunction

endpackage

`default_nettype wire

FILE: design/hvd_bam.sv
// ----------------------------------------------------------------------------
// hvd_bam
// Fixed-point degrees to binary angle, rounded half away from zero.
// Divide by 360 (or 720 for half angles) as a shift and two reciprocal
// multiplies by 1/45 with a one-step correction each.
// ----------------------------------------------------------------------------
`default_nettype none

module hvd_bam (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic               half,
	input  wire logic signed [31:0] delta,
	output logic         [31:0]     bam
);

	localparam int MW = hvd_pkg::MAG_W;
	localparam int SW = MW + 1;
	localparam int XW = MW - 2;
	localparam int DL = hvd_pkg::DIV_LO_W;
	localparam int HW = XW - DL;

	logic [31:0]    mag;
	logic [MW-1:0]  n;
	logic [SW-1:0]  sum;
	logic [XW-1:0]  x;

	logic [HW+26:0] ph_s1;
	logic [HW-1:0]  h_s1;
	logic [DL-1:0]  l_s1;
	logic           neg_s1;

	logic [HW-1:0]  qh0, rh0, qh, rh;
	logic [DL+5:0]  v;
	logic [HW-1:0]  qh_s2;
	logic [DL+5:0]  v_s2;
	logic [DL+32:0] pl_s2;
	logic           neg_s2;

	logic [DL:0]    ql0, ql;
	logic [DL+5:0]  rl0;
	logic [31:0]    q;
	logic [31:0]    bam_s3;

	always_comb begin
		mag = delta[31] ? 32'(-delta) : 32'(delta);
		n   = {mag, {hvd_pkg::BAM_SHIFT{1'b0}}};
		sum = {1'b0, n} + (half ? SW'(360) : SW'(180));
		x   = half ? XW'(sum >> 4) : XW'(sum >> 3);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ph_s1  <= x[XW-1:DL] * hvd_pkg::RECIP45;
			h_s1   <= x[XW-1:DL];
			l_s1   <= x[DL-1:0];
			neg_s1 <= delta[31];
		end
	end

	// high part quotient, remainder carried into the low part
	always_comb begin
		qh0 = HW'(ph_s1 >> 32);
		rh0 = h_s1 - HW'(qh0 * HW'(45));
		if (rh0 >= HW'(45)) begin
			qh = qh0 + HW'(1);
			rh = rh0 - HW'(45);
		end else begin
			qh = qh0;
			rh = rh0;
		end
		v = {rh[5:0], l_s1};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qh_s2  <= qh;
			v_s2   <= v;
			pl_s2  <= v * hvd_pkg::RECIP45;
			neg_s2 <= neg_s1;
		end
	end

	always_comb begin
		ql0 = pl_s2[DL+32:32];
		rl0 = v_s2 - (DL+6)'(ql0 * (DL+1)'(45));
		ql  = (rl0 >= (DL+6)'(45)) ? ql0 + (DL+1)'(1) : ql0;
		q   = 32'({qh_s2, {DL{1'b0}}}) + 32'(ql);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bam_s3 <= neg_s2 ? -q : q;
		end
	end

	assign bam = bam_s3;

endmodule

`default_nettype wire

FILE: design/hvd_sincos.sv
// ----------------------------------------------------------------------------
// hvd_sincos
// Rotation-mode CORDIC, one micro-rotation per pipeline stage.
// Quadrant fold first, sign restore in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hvd_sincos (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic        [31:0] bam,
	output logic signed      [31:0] cos_v,
	output logic signed      [31:0] sin_v
);

	localparam int N  = hvd_pkg::CORDIC_STAGES;
	localparam int CW = hvd_pkg::CORDIC_W;

	logic signed [CW-1:0] x_s [N+1];
	logic signed [CW-1:0] y_s [N+1];
	logic signed [CW-1:0] z_s [N+1];
	logic                 neg_s [N+1];
	logic signed [CW-1:0] z_in;
	logic signed [31:0]   cos_s, sin_s;

	assign z_in = CW'(signed'(bam));

	// fold into +-90 degrees, flip the result sign when folded
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= hvd_pkg::CORDIC_K;
			y_s[0] <= '0;
			if (z_in > hvd_pkg::QUARTER_TURN) begin
				z_s[0]   <= z_in - hvd_pkg::HALF_TURN;
				neg_s[0] <= 1'b1;
			end else if (z_in < -hvd_pkg::QUARTER_TURN) begin
				z_s[0]   <= z_in + hvd_pkg::HALF_TURN;
				neg_s[0] <= 1'b1;
			end else begin
				z_s[0]   <= z_in;
				neg_s[0] <= 1'b0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) begin
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - hvd_pkg::atan_angle(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + hvd_pkg::atan_angle(i);
				end
				neg_s[i+1] <= neg_s[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_s <= 32'(neg_s[N] ? -x_s[N] : x_s[N]);
			sin_s <= 32'(neg_s[N] ? -y_s[N] : y_s[N]);
		end
	end

	assign cos_v = cos_s;
	assign sin_v = sin_s;

endmodule

`default_nettype wire

FILE: design/hvd_isqrt.sv
// ----------------------------------------------------------------------------
// hvd_isqrt
// Exact integer square root of a Q30 value shifted up by 30 bits.
// Digit-by-digit, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hvd_isqrt (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [30:0] a,
	output logic      [30:0] root
);

	localparam int IT = hvd_pkg::ISQ_ITER;
	localparam int IW = 2 * IT - 1;

	logic [IW-1:0] v_s [IT+1];
	logic [IW-1:0] r_s [IT+1];

	always_ff @(posedge clk) begin
		if (en) begin
			v_s[0] <= IW'({a, 30'b0});
			r_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < IT; i++) begin : g_step
		localparam logic [IW-1:0] BIT = IW'(1) << (IW - 1 - 2 * i);
		logic [IW-1:0] t;
		assign t = r_s[i] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (v_s[i] >= t) begin
					v_s[i+1] <= v_s[i] - t;
					r_s[i+1] <= (r_s[i] >> 1) + BIT;
				end else begin
					v_s[i+1] <= v_s[i];
					r_s[i+1] <= r_s[i] >> 1;
				end
			end
		end
	end

	assign root = r_s[IT][30:0];

endmodule

`default_nettype wire

FILE: design/hvd_atan2.sv
// ----------------------------------------------------------------------------
// hvd_atan2
// Vectoring-mode CORDIC atan2 for the first quadrant, binary-angle result.
// One micro-rotation per pipeline stage; negative angles clamp to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module hvd_atan2 (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [30:0] x_in,
	input  wire logic [30:0] y_in,
	output logic      [31:0] angle
);

	localparam int N  = hvd_pkg::CORDIC_STAGES;
	localparam int CW = hvd_pkg::CORDIC_W;

	logic signed [CW-1:0] x_s [N+1];
	logic signed [CW-1:0] y_s [N+1];
	logic signed [CW-1:0] z_s [N+1];
	logic [31:0]          angle_s;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= CW'(x_in);
			y_s[0] <= CW'(y_in);
			z_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + hvd_pkg::atan_angle(i);
				end else if (y_s[i] < 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - hvd_pkg::atan_angle(i);
				end else begin
					x_s[i+1] <= x_s[i];
					y_s[i+1] <= y_s[i];
					z_s[i+1] <= z_s[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_s <= (z_s[N] < 0) ? 32'd0 : 32'(z_s[N]);
		end
	end

	assign angle = angle_s;

endmodule

`default_nettype wire

FILE: design/haversine_distance.sv
// Haversine great-circle distance to a stored home position.
// Throughput: one position per cycle unless stalled; the CORDIC and root chains are fully unrolled.
// The whole pipeline holds while a result waits at the output register.
// Reset clears all valid bits and loads home 0/0 and radius 20908120.
// ----------------------------------------------------------------------------
// haversine_distance
// Top level: config registers, half-angle sines, haversine term, roots,
// atan2 and final scaling to distance units with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module haversine_distance (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic        [1:0]  cfg_index,
	input  wire logic        [30:0] cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [30:0] here_latitude,
	input  wire logic signed [30:0] here_longitude,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic             [31:0] distance
);

	localparam int LAT    = hvd_pkg::TOTAL_LAT;
	localparam int A_IDX  = hvd_pkg::BAM_LAT + hvd_pkg::SC_LAT + hvd_pkg::PROD_LAT - 1;

	logic signed [30:0] home_lat_q, home_lon_q;
	logic [hvd_pkg::RADIUS_W-1:0] radius_q;
	logic [LAT-1:0] vld_q;
	logic en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			home_lat_q <= '0;
			home_lon_q <= '0;
			radius_q   <= hvd_pkg::RADIUS_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				hvd_pkg::REG_HOME_LAT: home_lat_q <= cfg_data;
				hvd_pkg::REG_HOME_LON: home_lon_q <= cfg_data;
				hvd_pkg::REG_RADIUS:   radius_q   <= cfg_data[hvd_pkg::RADIUS_W-1:0];
				default: ;
			endcase
		end
	end

	// global advance: hold everything while the result is not taken
	assign en        = !vld_q[LAT-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// angle conversion
	logic signed [31:0] dlat, dlon, lat1, lat2;
	logic [31:0] bam_dlat, bam_dlon, bam_lat1, bam_lat2;

	assign lat1 = 32'(here_latitude);
	assign lat2 = 32'(home_lat_q);
	assign dlat = lat2 - lat1;
	assign dlon = 32'(home_lon_q) - 32'(here_longitude);

	hvd_bam u_bam_dlat (.clk, .en, .half(1'b1), .delta(dlat), .bam(bam_dlat));
	hvd_bam u_bam_dlon (.clk, .en, .half(1'b1), .delta(dlon), .bam(bam_dlon));
	hvd_bam u_bam_lat1 (.clk, .en, .half(1'b0), .delta(lat1), .bam(bam_lat1));
	hvd_bam u_bam_lat2 (.clk, .en, .half(1'b0), .delta(lat2), .bam(bam_lat2));

	logic signed [31:0] sin_dlat, sin_dlon, cos_lat1, cos_lat2;

	hvd_sincos u_sc_dlat (.clk, .en, .bam(bam_dlat), .cos_v(), .sin_v(sin_dlat));
	hvd_sincos u_sc_dlon (.clk, .en, .bam(bam_dlon), .cos_v(), .sin_v(sin_dlon));
	hvd_sincos u_sc_lat1 (.clk, .en, .bam(bam_lat1), .cos_v(cos_lat1), .sin_v());
	hvd_sincos u_sc_lat2 (.clk, .en, .bam(bam_lat2), .cos_v(cos_lat2), .sin_v());

	// haversine term a, Q30, products floor-shifted
	logic signed [63:0] sqlat_w, sqlon_w, cc_w, t_w;
	logic signed [31:0] sqlat_s1, sqlon_s1, cc_s1;
	logic signed [31:0] sqlat_s2, t_s2;
	logic signed [32:0] asum;
	logic [30:0] a_s3, b_s3, a_nx;

	always_comb begin
		sqlat_w = sin_dlat * sin_dlat;
		sqlon_w = sin_dlon * sin_dlon;
		cc_w    = cos_lat1 * cos_lat2;
		t_w     = cc_s1 * sqlon_s1;
		asum    = 33'(sqlat_s2) + 33'(t_s2);
		if (asum < 0) begin
			a_nx = '0;
		end else if (asum > signed'(33'(hvd_pkg::Q30_ONE))) begin
			a_nx = hvd_pkg::Q30_ONE;
		end else begin
			a_nx = asum[30:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqlat_s1 <= 32'(sqlat_w >>> 30);
			sqlon_s1 <= 32'(sqlon_w >>> 30);
			cc_s1    <= 32'(cc_w >>> 30);
			sqlat_s2 <= sqlat_s1;
			t_s2     <= 32'(t_w >>> 30);
			a_s3     <= a_nx;
			b_s3     <= hvd_pkg::Q30_ONE - a_nx;
		end
	end

	logic [30:0] root_a, root_b;
	logic [31:0] z_ang;

	hvd_isqrt u_sqrt_a (.clk, .en, .a(a_s3), .root(root_a));
	hvd_isqrt u_sqrt_b (.clk, .en, .a(b_s3), .root(root_b));
	hvd_atan2 u_atan2  (.clk, .en, .x_in(root_b), .y_in(root_a), .angle(z_ang));

	// central angle in Q32, then scale by radius with round half up
	logic [62:0] zp_s1;
	logic [35:0] theta_s2;
	logic [61:0] dp_s3;
	logic [62:0] dr;
	logic [31:0] dist_s4;

	always_comb begin
		dr = (63'(dp_s3) + (63'(1) << (hvd_pkg::DIST_SHIFT - 1))) >> hvd_pkg::DIST_SHIFT;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zp_s1    <= z_ang * hvd_pkg::PI_Q29;
			theta_s2 <= 36'((zp_s1 + (63'(1) << (hvd_pkg::THETA_SHIFT - 1)))
				>> hvd_pkg::THETA_SHIFT);
			dp_s3    <= radius_q * theta_s2;
			dist_s4  <= (|dr[62:32]) ? '1 : dr[31:0];
		end
	end

	assign distance = dist_s4;

`ifndef SYNTHESIS
	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("valid bits moved during a stall");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_q[0])
		else $error("accepted transfer not tracked");

	a_term_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[A_IDX] |-> (a_s3 <= hvd_pkg::Q30_ONE))
		else $error("haversine term out of range");

	a_zero_radius: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && radius_q == '0) |-> (distance == '0))
		else $error("nonzero distance with zero radius");
`endif

endmodule

`default_nettype wire

FILE: test/haversine_distance_tb.sv
// ----------------------------------------------------------------------------
// haversine_distance_tb
// Self-checking bench: drives position queries against several home/radius
// settings, predicts each distance in fixed point and checks every transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module haversine_distance_tb;

	localparam int LATENCY     = hvd_pkg::TOTAL_LAT;
	localparam int CYCLE_LIMIT = 400000;

	// index past the last register, writes to it are dropped
	localparam logic [1:0] REG_UNUSED = 2'd3;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_write = 1'b0;
	logic        [1:0]  cfg_index = '0;
	logic        [30:0] cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [30:0] here_latitude = '0;
	logic signed [30:0] here_longitude = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic        [31:0] distance;

	haversine_distance i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.here_latitude(here_latitude), .here_longitude(here_longitude),
		.out_valid(out_valid), .out_ready(out_ready), .distance(distance)
	);

	always #6 clk = ~clk;

	// predictor state
	logic signed [30:0] home_lat_q = '0;
	logic signed [30:0] home_lon_q = '0;
	logic        [25:0] radius_q = hvd_pkg::RADIUS_RESET;

	logic [31:0] dist_expected[$];
	int          error_count = 0;
	int          result_count = 0;
	int          cycle_count = 0;
	bit          idle_enable = 1'b1;
	int          stall_cycles = 0;
	int          hold_request = 0;

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint deg_to_bam(longint deg, longint div);
		longint n, q;
		n = deg * (longint'(1) << hvd_pkg::BAM_SHIFT);
		q = (n >= 0) ? (n + div / 2) / div : (n - div / 2) / div;
		return q & 64'hFFFF_FFFF;
	endfunction

	function automatic longint atan_step(int i);
		longint tab[32] = '{
			'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
			'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
			'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
			'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
			'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001,
			'h00000001, 'h00000000};
		return tab[i];
	endfunction

	task automatic rotate(input longint b, output longint c, output longint s);
		longint z, x, y, t;
		bit neg;
		z = b; x = 652032874; y = 0; neg = 0;
		if (z >= (longint'(1) << 31)) z -= (longint'(1) << 32);
		if (z > (longint'(1) << 30)) begin
			z -= (longint'(1) << 31); neg = 1;
		end else if (z < -(longint'(1) << 30)) begin
			z += (longint'(1) << 31); neg = 1;
		end
		for (int i = 0; i < hvd_pkg::CORDIC_STAGES; i++) begin
			if (z >= 0) begin
				t = x - floor_shift(y, i); y = y + floor_shift(x, i); x = t;
				z -= atan_step(i);
			end else begin
				t = x + floor_shift(y, i); y = y - floor_shift(x, i); x = t;
				z += atan_step(i);
			end
		end
		c = neg ? -x : x;
		s = neg ? -y : y;
	endtask

	function automatic longint int_root(longint unsigned v);
		longint unsigned r, b;
		r = 0; b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b; r = (r >> 1) + b;
			end else r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	task automatic predict_distance(input logic signed [30:0] lat, input logic signed [30:0] lon,
			output logic [31:0] d_out);
		longint ch, sh, c1, s1, c2, s2, a, z, x, y, t, theta;
		longint unsigned d;
		rotate(deg_to_bam(longint'(home_lat_q) - longint'(lat), 720), ch, sh);
		a = floor_shift(sh * sh, 30);
		rotate(deg_to_bam(longint'(home_lon_q) - longint'(lon), 720), ch, sh);
		rotate(deg_to_bam(longint'(lat), 360), c1, s1);
		rotate(deg_to_bam(longint'(home_lat_q), 360), c2, s2);
		a += floor_shift(floor_shift(c1 * c2, 30) * floor_shift(sh * sh, 30), 30);
		if (a < 0) a = 0;
		if (a > (longint'(1) << 30)) a = longint'(1) << 30;
		y = int_root(longint'(a) << 30);
		x = int_root(((longint'(1) << 30) - a) << 30);
		z = 0;
		for (int i = 0; i < hvd_pkg::CORDIC_STAGES; i++) begin
			if (y > 0) begin
				t = x + floor_shift(y, i); y = y - floor_shift(x, i); x = t;
				z += atan_step(i);
			end else if (y < 0) begin
				t = x - floor_shift(y, i); y = y + floor_shift(x, i); x = t;
				z -= atan_step(i);
			end
		end
		if (z < 0) z = 0;
		theta = (z * 1686629713 + (longint'(1) << 26)) >>> 27;
		d = (longint'(radius_q) * theta + (64'd1 << (31 - hvd_pkg::DIST_FRAC_BITS)))
			>> hvd_pkg::DIST_SHIFT;
		d_out = (d > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
	endtask

	// valid stays up after a transfer; wait_drained or a random idle gap in the next item takes it down
	task automatic send_position(input logic signed [30:0] lat, input logic signed [30:0] lon);
		logic [31:0] d;
		if (idle_enable && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		predict_distance(lat, lon, d);
		in_valid <= 1'b1;
		here_latitude <= lat;
		here_longitude <= lon;
		do @(posedge clk); while (!in_ready);
		dist_expected.push_back(d);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (dist_expected.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
		cfg_write <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			hvd_pkg::REG_HOME_LAT: home_lat_q = val;
			hvd_pkg::REG_HOME_LON: home_lon_q = val;
			hvd_pkg::REG_RADIUS:   radius_q = val[25:0];
			default: ;
		endcase
	endtask

	function automatic logic signed [30:0] rand_angle();
		case ($urandom_range(0, 3))
			0: return 31'($urandom);
			1: return 31'($signed($urandom_range(0, 1509949440)) - 754974720);
			default: return 31'($signed($urandom_range(0, 754974720)) - 377487360);
		endcase
	endfunction

	// receiver: random back-pressure plus one long hold-off
	always @(negedge clk) begin
		if (hold_request > 0) begin
			stall_cycles <= hold_request;
			hold_request = 0;
			out_ready <= 1'b0;
		end else if (stall_cycles > 0) begin
			stall_cycles <= stall_cycles - 1;
			out_ready <= 1'b0;
		end else if (idle_enable && $urandom_range(0, 9) == 0)
			stall_cycles <= $urandom_range(1, 12);
		else
			out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		logic [31:0] want;
		cycle_count <= cycle_count + 1;
		if (arst_n && out_valid && out_ready) begin
			result_count <= result_count + 1;
			if (dist_expected.size() == 0) begin
				$display("%0t: unexpected distance transfer, actual %h", $realtime, distance);
				error_count <= error_count + 1;
			end else begin
				want = dist_expected.pop_front();
				if (distance !== want) begin
					$display("%0t: distance mismatch, expected %h, actual %h",
						$realtime, want, distance);
					error_count <= error_count + 1;
				end
			end
		end
		if (cycle_count > CYCLE_LIMIT) begin
			$display("haversine_distance_tb: done, errors");
			$finish;
		end
	end

	task automatic test_directed();
		logic signed [30:0] edges[8] = '{31'sd0, 31'sd754974720, -31'sd754974720,
			31'sd377487360, -31'sd377487360, 31'h3FFF_FFFF, 31'h4000_0000, 31'sd1};
		foreach (edges[i]) send_position(edges[i], edges[7 - i]);
		send_position(31'sd377487360, 31'sd0);
		send_position(-31'sd377487360, 31'sd754974720);
		send_position(31'sd754974720, 31'sd754974720);
		send_position(31'sd0, 31'sd754974720);
	endtask

	task automatic test_home_settings();
		logic signed [30:0] homes[4] = '{31'sd754974720, -31'sd754974720, 31'sd0, 31'h3FFF_FFFF};
		for (int k = 0; k < 4; k++) begin
			wait_drained();
			write_reg(hvd_pkg::REG_HOME_LAT, homes[k]);
			write_reg(hvd_pkg::REG_HOME_LON, homes[3 - k]);
			write_reg(REG_UNUSED, 31'h7FFF_FFFF);
			send_position(homes[k], homes[3 - k]);
			send_position(-homes[k], 31'sd0);
			send_position(31'sd377487360, -31'sd754974720);
		end
	endtask

	task automatic test_radius_extremes();
		logic [25:0] radii[3] = '{26'd1, 26'h3FF_FFFF, 26'd0};
		foreach (radii[i]) begin
			wait_drained();
			write_reg(hvd_pkg::REG_RADIUS, {5'd0, radii[i]});
			send_position(31'sd754974720, -31'sd754974720);
			send_position(31'sd377487360, 31'sd12345);
		end
	endtask

	task automatic test_backpressure();
		wait_drained();
		write_reg(hvd_pkg::REG_RADIUS, {5'd0, hvd_pkg::RADIUS_RESET});
		@(negedge clk);
		hold_request = 300;
		repeat (200) send_position(rand_angle(), rand_angle());
	endtask

	task automatic test_random();
		for (int phase = 0; phase < 6; phase++) begin
			wait_drained();
			write_reg(hvd_pkg::REG_HOME_LAT, rand_angle());
			write_reg(hvd_pkg::REG_HOME_LON, rand_angle());
			write_reg(hvd_pkg::REG_RADIUS, 31'($urandom_range(phase == 0 ? 0 : 1, 67108863)));
			if (phase == 5) idle_enable = 1'b0;
			repeat (275) send_position(rand_angle(), rand_angle());
		end
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_home_settings();
		test_radius_extremes();
		test_backpressure();
		test_random();
		wait_drained();
		$display("covered: edge angles, wrap past 180 deg, radius 0/1/max, home moves,");
		$display("  %0d distance transfers with random and long output stalls", result_count);
		if (error_count == 0)
			$display("haversine_distance_tb: done, clean");
		else
			$display("haversine_distance_tb: done, errors");
		$finish;
	end

endmodule

`default_nettype wire

FILE: haversine_distance.f
design/hvd_pkg.sv
design/hvd_bam.sv
design/hvd_sincos.sv
design/hvd_isqrt.sv
design/hvd_atan2.sv
design/haversine_distance.sv
test/haversine_distance_tb.sv
